// ----- hw/rtl/imupfp_pkg.sv -----
// Package for the IMU packet field parser: widths, codes, result struct and the
// field length table. No dependencies.
package imupfp_pkg;

    localparam int NUM_FIELDS   = 23;
    localparam int NUM_GROUPS   = 7;
    localparam int FID_W        = 5;
    localparam int OFF_W        = 5;
    localparam int ST_W         = 2;

    localparam logic [7:0] SYNC_BYTE = 8'hFA;

    localparam logic [ST_W-1:0] ST_PAYLOAD  = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_SYNC = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [ST_W-1:0]  status;
        logic [FID_W-1:0] field_id;
        logic [OFF_W-1:0] byte_offset;
        logic [7:0]       data_byte;
        logic             last;
    } t_result;

    function automatic logic [OFF_W-1:0] fld_len(input logic [FID_W-1:0] f);
        logic [OFF_W-1:0] len;
        case (f)
            5'd0:  len = 5'd0;
            5'd1:  len = 5'd12;
            5'd2:  len = 5'd12;
            5'd3:  len = 5'd12;
            5'd4:  len = 5'd4;
            5'd5:  len = 5'd4;
            5'd6:  len = 5'd16;
            5'd7:  len = 5'd12;
            5'd8:  len = 5'd12;
            5'd9:  len = 5'd12;
            5'd10: len = 5'd12;
            5'd11: len = 5'd2;
            5'd12: len = 5'd2;
            5'd13: len = 5'd24;
            5'd14: len = 5'd24;
            5'd15: len = 5'd12;
            5'd16: len = 5'd12;
            5'd17: len = 5'd12;
            5'd18: len = 5'd12;
            5'd19: len = 5'd12;
            5'd20: len = 5'd12;
            5'd21: len = 5'd4;
            5'd22: len = 5'd4;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/imupfp_if.sv -----
// Valid/ready channel interfaces for the IMU packet field parser.
// Depends on imupfp_pkg for field widths.
interface imupfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       packet_start;

    modport source (output valid, output rx_byte, output packet_start, input ready);
    modport sink   (input valid, input rx_byte, input packet_start, output ready);
endinterface

interface imupfp_out_if import imupfp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [FID_W-1:0] field_id;
    logic [OFF_W-1:0] byte_offset;
    logic [7:0]       data_byte;
    logic             last;

    modport source (output valid, output status, output field_id, output byte_offset,
                    output data_byte, output last, input ready);
    modport sink   (input valid, input status, input field_id, input byte_offset,
                    input data_byte, input last, output ready);
endinterface

// ----- hw/rtl/imupfp_core.sv -----
// Parser state and per-byte decode: header tracking, field selection and
// payload tagging. Depends on imupfp_pkg.
module imupfp_core
    import imupfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_packet_start,
    output t_result    o_result
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_GROUPS  = 2'd1;
    localparam logic [1:0] PH_MASKS   = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    logic [1:0]            r_phase,   n_phase;
    logic [NUM_GROUPS-1:0] r_grp_rem, n_grp_rem;
    logic                  r_hi,      n_hi;
    logic [NUM_FIELDS-1:0] r_sel,     n_sel;
    logic [FID_W-1:0]      r_field,   n_field;
    logic [OFF_W-1:0]      r_off,     n_off;

    logic [NUM_GROUPS-1:0] grp_low;
    logic [NUM_FIELDS-1:0] above;
    logic [NUM_FIELDS-1:0] hdr_pick;
    logic [NUM_FIELDS-1:0] pay_pick;
    logic                  hdr_found, pay_found;
    logic [FID_W-1:0]      hdr_idx,   pay_idx;
    logic                  field_end;
    logic                  hdr_done;
    t_result               res;

    function automatic logic [FID_W:0] first_set(input logic [NUM_FIELDS-1:0] v);
        logic [FID_W:0] r;
        r = '0;
        for (int i = NUM_FIELDS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = {1'b1, FID_W'(i)};
            end
        end
        return r;
    endfunction

    assign grp_low = r_grp_rem & (~r_grp_rem + NUM_GROUPS'(1));

    always_comb begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
            above[i] = (FID_W'(i) > r_field);
        end
    end

    always_comb begin
        n_sel = r_sel;
        if (i_accept && !i_packet_start) begin
            case (r_phase)
                PH_GROUPS: begin
                    n_sel = '0;
                end
                PH_MASKS: begin
                    if (!r_hi) begin
                        if (grp_low[2]) n_sel[7:1]   = i_rx_byte[7:1];
                        if (grp_low[5]) n_sel[19:12] = i_rx_byte;
                    end else begin
                        if (grp_low[2]) n_sel[11:8]  = i_rx_byte[3:0];
                        if (grp_low[5]) n_sel[22:20] = i_rx_byte[2:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign hdr_pick                = n_sel;
    assign pay_pick                = r_sel & above;
    assign {pay_found, pay_idx}    = first_set(pay_pick);
    assign {hdr_found, hdr_idx}    = first_set(hdr_pick);
    assign field_end = ({1'b0, r_off} + 6'd1) >= {1'b0, fld_len(r_field)};

    always_comb begin
        n_phase   = r_phase;
        n_grp_rem = r_grp_rem;
        n_hi      = r_hi;
        n_field   = r_field;
        n_off     = r_off;
        res       = '0;
        hdr_done  = 1'b0;

        if (i_accept) begin
            if (i_packet_start) begin
                if (i_rx_byte != SYNC_BYTE) begin
                    n_phase    = PH_IDLE;
                    res.valid  = 1'b1;
                    res.status = ST_BAD_SYNC;
                end else begin
                    n_phase = PH_GROUPS;
                end
            end else begin
                case (r_phase)
                    PH_GROUPS: begin
                        n_grp_rem = i_rx_byte[NUM_GROUPS-1:0];
                        n_hi      = 1'b0;
                        if (i_rx_byte[NUM_GROUPS-1:0] == '0) begin
                            hdr_done = 1'b1;
                        end else begin
                            n_phase = PH_MASKS;
                        end
                    end
                    PH_MASKS: begin
                        if (r_hi) begin
                            n_grp_rem = r_grp_rem & ~grp_low;
                        end
                        n_hi     = ~r_hi;
                        hdr_done = r_hi && ((r_grp_rem & ~grp_low) == '0);
                    end
                    PH_PAYLOAD: begin
                        res.valid       = 1'b1;
                        res.status      = ST_PAYLOAD;
                        res.field_id    = r_field;
                        res.byte_offset = r_off;
                        res.data_byte   = i_rx_byte;
                        if (field_end) begin
                            n_off = '0;
                            if (pay_found) begin
                                n_field = pay_idx;
                            end else begin
                                res.last = 1'b1;
                                n_phase  = PH_IDLE;
                            end
                        end else begin
                            n_off = r_off + OFF_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase

                if (hdr_done) begin
                    if (hdr_found) begin
                        n_field = hdr_idx;
                        n_off   = '0;
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase    = PH_IDLE;
                        res.valid  = 1'b1;
                        res.status = ST_EMPTY;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_grp_rem <= '0;
            r_hi      <= 1'b0;
            r_sel     <= '0;
            r_field   <= '0;
            r_off     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_grp_rem <= n_grp_rem;
            r_hi      <= n_hi;
            r_sel     <= n_sel;
            r_field   <= n_field;
            r_off     <= n_off;
        end
    end

    assign o_result = res;

    a_field_selected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_sel[r_field])
        else $error("payload field not selected");

    a_offset_in_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_off < fld_len(r_field))
        else $error("byte offset beyond field length");

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && res.status != ST_PAYLOAD) |->
            (res.field_id == '0 && res.byte_offset == '0 && res.data_byte == '0 && !res.last))
        else $error("non-payload result carries payload fields");

    a_sel_zero_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sel[0])
        else $error("zero-length field selected");

endmodule

// ----- hw/rtl/imupfp_out_reg.sv -----
// Result register between the parser and the output channel.
// Depends on imupfp_pkg.
module imupfp_out_reg
    import imupfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_result,
    input  logic    i_out_ready,
    output logic    o_load_ok,
    output t_result o_result
);

    logic    r_valid;
    t_result r_data;

    assign o_load_ok = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.valid) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_data <= i_result;
        end
    end

    always_comb begin
        o_result       = r_data;
        o_result.valid = r_valid;
    end

endmodule

// ----- hw/rtl/imu_packet_field_parser.sv -----
// Top level of the IMU packet field parser: parser core plus result register.
// Depends on imupfp_pkg, imupfp_if, imupfp_core and imupfp_out_reg.
//
//   port    dir  content
//   i_in    in   rx_byte, packet_start (one packet byte per transfer)
//   o_out   out  status, field_id, byte_offset, data_byte, last (0 or 1 per byte)
//
// One byte per cycle unless o_out stalls; results show the cycle after their byte.
// The result register sets the pace: a byte is taken whenever it is empty or
// drained in the same cycle.
// Synchronous active-low reset returns the parser to idle with empty masks.
// A stall on o_out holds i_in.ready low until the pending result is taken.
module imu_packet_field_parser
    import imupfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    imupfp_in_if.sink          i_in,
    imupfp_out_if.source       o_out
);

    logic    load_ok;
    logic    accept;
    t_result core_res;
    t_result out_res;

    assign i_in.ready = load_ok;
    assign accept     = i_in.valid && load_ok;

    imupfp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_rx_byte      (i_in.rx_byte),
        .i_packet_start (i_in.packet_start),
        .o_result       (core_res)
    );

    imupfp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (core_res),
        .i_out_ready (o_out.ready),
        .o_load_ok   (load_ok),
        .o_result    (out_res)
    );

    assign o_out.valid       = out_res.valid;
    assign o_out.status      = out_res.status;
    assign o_out.field_id    = out_res.field_id;
    assign o_out.byte_offset = out_res.byte_offset;
    assign o_out.data_byte   = out_res.data_byte;
    assign o_out.last        = out_res.last;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for imu_packet_field_parser: directed packets from a table, then random
// packets, all checked against a parser model kept here. Depends on imupfp_pkg, imupfp_if.
module tb_top;
    import imupfp_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 700;
    localparam int QUIET_ITEMS   = 120;
    localparam int LONG_HOLD     = 400;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int GROUP_A       = 2;
    localparam int GROUP_B       = 5;
    localparam int FIRST_B_FIELD = 12;
    localparam int FIELD_BYTES [NUM_FIELDS] = '{
        0, 12, 12, 12, 4, 4, 16, 12, 12, 12, 12, 2,
        2, 24, 24, 12, 12, 12, 12, 12, 12, 4, 4
    };

    typedef enum logic [1:0] {PS_IDLE, PS_GROUPS, PS_MASKS, PS_PAYLOAD} t_parse_phase;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [FID_W-1:0] field_id;
        logic [OFF_W-1:0] byte_offset;
        logic [7:0]       data_byte;
        logic             last;
    } t_field_byte;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic        packet_start;
        logic        typed;
        t_field_byte result;
    } t_byte_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    imupfp_in_if  byte_ch ();
    imupfp_out_if result_ch ();

    imu_packet_field_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (result_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    t_parse_phase ps_phase     = PS_IDLE;
    logic [6:0]   ps_groups    = '0;
    logic [15:0]  ps_masks [NUM_GROUPS];
    logic [3:0]   ps_hdr_cnt   = '0;
    logic [4:0]   ps_field     = '0;
    logic [4:0]   ps_byte_cnt  = '0;

    t_field_byte expected_bytes [$];
    t_byte_row   offered_rows [$];
    int          mismatches   = 0;
    int          packet_bytes = 0;
    int          cycle_count  = 0;
    bit          quiet_tail   = 1'b0;
    bit          long_hold_req = 1'b0;

    initial foreach (ps_masks[g]) ps_masks[g] = '0;

    function automatic bit field_enabled(input int f);
        if (f >= NUM_FIELDS || FIELD_BYTES[f] == 0) return 1'b0;
        if (f < FIRST_B_FIELD) return ps_masks[GROUP_A][f];
        return ps_masks[GROUP_B][f - FIRST_B_FIELD];
    endfunction

    function automatic int first_field_from(input int from);
        for (int f = from; f < NUM_FIELDS; f++)
            if (field_enabled(f)) return f;
        return NUM_FIELDS;
    endfunction

    function automatic bit enter_payload(output t_field_byte r);
        int f;
        r = '0;
        f = first_field_from(0);
        if (f >= NUM_FIELDS) begin
            ps_phase = PS_IDLE;
            r.status = ST_EMPTY;
            return 1'b1;
        end
        ps_field    = 5'(f);
        ps_byte_cnt = '0;
        ps_phase    = PS_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic s,
                                      output t_field_byte r);
        int hb;
        int k;
        int g;
        int nf;
        r = '0;
        if (s) begin
            if (b != SYNC_BYTE) begin
                ps_phase = PS_IDLE;
                r.status = ST_BAD_SYNC;
                return 1'b1;
            end
            ps_phase = PS_GROUPS;
            return 1'b0;
        end
        case (ps_phase)
            PS_GROUPS: begin
                ps_groups = b[6:0];
                foreach (ps_masks[i]) ps_masks[i] = '0;
                ps_hdr_cnt = '0;
                if (ps_groups == '0) return enter_payload(r);
                ps_phase = PS_MASKS;
                return 1'b0;
            end
            PS_MASKS: begin
                hb = ps_hdr_cnt;
                k  = hb >> 1;
                g  = -1;
                for (int i = 0; i < NUM_GROUPS; i++) begin
                    if (ps_groups[i] && g < 0) begin
                        if (k == 0) g = i;
                        else k--;
                    end
                end
                if (hb[0]) ps_masks[g][15:8] = b;
                else ps_masks[g][7:0] = b;
                ps_hdr_cnt = ps_hdr_cnt + 4'd1;
                if (hb + 1 >= 2 * $countones(ps_groups)) return enter_payload(r);
                return 1'b0;
            end
            PS_PAYLOAD: begin
                r.status      = ST_PAYLOAD;
                r.field_id    = ps_field;
                r.byte_offset = ps_byte_cnt;
                r.data_byte   = b;
                if (int'(ps_byte_cnt) + 1 >= FIELD_BYTES[ps_field]) begin
                    nf = first_field_from(int'(ps_field) + 1);
                    if (nf >= NUM_FIELDS) begin
                        r.last   = 1'b1;
                        ps_phase = PS_IDLE;
                    end else begin
                        ps_field = 5'(nf);
                    end
                    ps_byte_cnt = '0;
                end else begin
                    ps_byte_cnt = ps_byte_cnt + 5'd1;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_byte_row plain_row(input logic [7:0] b, input logic s);
        t_byte_row row;
        row = '0;
        row.rx_byte      = b;
        row.packet_start = s;
        return row;
    endfunction

    function automatic t_byte_row typed_row(input logic [7:0] b, input logic s,
                                            input logic [ST_W-1:0] st);
        t_byte_row row;
        row = plain_row(b, s);
        row.typed         = 1'b1;
        row.result.status = st;
        return row;
    endfunction

    task automatic send_row(input t_byte_row row);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        offered_rows.push_back(row);
        byte_ch.valid        <= 1'b1;
        byte_ch.rx_byte      <= row.rx_byte;
        byte_ch.packet_start <= row.packet_start;
        do @(posedge i_clk); while (!byte_ch.ready);
    endtask

    task automatic send_random_packet();
        logic [7:0]  group_byte;
        logic [15:0] mask [NUM_GROUPS];
        logic [7:0]  pkt [$];
        int          payload_len;
        int          cut;
        int          pick;
        bit          sel;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            repeat ($urandom_range(1, 3)) send_row(plain_row(8'($urandom), 1'b0));
            return;
        end
        if (pick == 1) begin
            send_row(plain_row(8'($urandom), 1'b1));
            packet_bytes++;
            return;
        end
        group_byte = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
            group_byte[($urandom_range(0, 1) != 0) ? GROUP_A : GROUP_B] = 1'b1;
        pkt.push_back(group_byte);
        for (int g = 0; g < NUM_GROUPS; g++) begin
            case ($urandom_range(0, 19))
                0:       mask[g] = 16'hFFFF;
                1, 2:    mask[g] = 16'($urandom);
                3, 4, 5: mask[g] = '0;
                default: mask[g] = 16'($urandom & $urandom & $urandom);
            endcase
            if (group_byte[g]) begin
                pkt.push_back(mask[g][7:0]);
                pkt.push_back(mask[g][15:8]);
            end
        end
        payload_len = 0;
        for (int f = 0; f < NUM_FIELDS; f++) begin
            if (f < FIRST_B_FIELD) sel = group_byte[GROUP_A] && mask[GROUP_A][f];
            else sel = group_byte[GROUP_B] && mask[GROUP_B][f - FIRST_B_FIELD];
            if (sel) payload_len += FIELD_BYTES[f];
        end
        repeat (payload_len) pkt.push_back(8'($urandom));
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, pkt.size() - 1) : pkt.size();
        send_row(plain_row(SYNC_BYTE, 1'b1));
        packet_bytes++;
        for (int i = 0; i < cut; i++) begin
            send_row(plain_row(pkt[i], 1'b0));
            packet_bytes++;
            quiet_tail = (packet_bytes > RANDOM_ITEMS - QUIET_ITEMS);
        end
        repeat ($urandom_range(0, 2)) send_row(plain_row(8'($urandom), 1'b0));
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_byte_row   row;
        t_field_byte predicted;
        t_field_byte want;
        t_field_byte got;
        bit          produced;
        if (i_rst_n) begin
            if (byte_ch.valid && byte_ch.ready) begin
                row      = offered_rows.pop_front();
                produced = parse_byte(byte_ch.rx_byte, byte_ch.packet_start, predicted);
                if (row.typed) begin
                    produced  = 1'b1;
                    predicted = row.result;
                end
                if (produced) expected_bytes.push_back(predicted);
            end
            if (result_ch.valid && result_ch.ready) begin
                got.status      = result_ch.status;
                got.field_id    = result_ch.field_id;
                got.byte_offset = result_ch.byte_offset;
                got.data_byte   = result_ch.data_byte;
                got.last        = result_ch.last;
                if (expected_bytes.size() == 0) begin
                    $error("unexpected result: status %0d field_id %0d byte_offset %0d",
                           got.status, got.field_id, got.byte_offset);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("field_id", want.field_id, got.field_id);
                    check_field("byte_offset", want.byte_offset, got.byte_offset);
                    check_field("data_byte", want.data_byte, got.data_byte);
                    check_field("last", want.last, got.last);
                end
            end
        end
    end

    initial begin : result_sink
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** imu_packet_field_parser: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        t_byte_row directed_rows [$];
        directed_rows = '{
            plain_row(8'h00, 1'b0),
            typed_row(8'h55, 1'b1, ST_BAD_SYNC),
            plain_row(8'hFA, 1'b0),
            plain_row(8'hFA, 1'b1),
            typed_row(8'h00, 1'b0, ST_EMPTY),
            plain_row(8'hFA, 1'b1),
            typed_row(8'h80, 1'b0, ST_EMPTY),
            plain_row(8'hFA, 1'b1),
            plain_row(8'h24, 1'b0),
            plain_row(8'h01, 1'b0),
            plain_row(8'h08, 1'b0),
            plain_row(8'h00, 1'b0),
            plain_row(8'h00, 1'b0),
            plain_row(8'h00, 1'b0),
            plain_row(8'hFF, 1'b0),
            plain_row(8'h3C, 1'b0),
            plain_row(8'hFA, 1'b1),
            plain_row(8'h41, 1'b0),
            plain_row(8'hFF, 1'b0),
            plain_row(8'hFF, 1'b0),
            plain_row(8'hFF, 1'b0),
            typed_row(8'hFF, 1'b0, ST_EMPTY),
            plain_row(8'hFA, 1'b1),
            plain_row(8'h04, 1'b0),
            typed_row(8'h00, 1'b1, ST_BAD_SYNC),
            typed_row(8'hFF, 1'b1, ST_BAD_SYNC)
        };
        i_rst_n              <= 1'b0;
        byte_ch.valid        <= 1'b0;
        byte_ch.rx_byte      <= '0;
        byte_ch.packet_start <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[i]) send_row(directed_rows[i]);
        long_hold_req = 1'b1;
        while (packet_bytes < RANDOM_ITEMS) send_random_packet();
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_bytes.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("** imu_packet_field_parser: PASSED **");
        end else begin
            $display("** imu_packet_field_parser: FAILED **");
        end
        $finish;
    end

endmodule
